FILE: hw/rtl/mncr_pkg.sv
`default_nettype none

package mncr_pkg;

	localparam int unsigned CH_W       = 4;
	localparam int unsigned NOTE_W     = 7;
	localparam int unsigned SLOT_W     = CH_W + NOTE_W;
	localparam int unsigned TABLE_DEPTH = 1 << SLOT_W;
	localparam int unsigned CFG_DATA_W = 4;

	localparam logic [7:0]      SYSTEM_STATUS = 8'hF0;
	localparam logic [CH_W-1:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [CH_W-1:0] KIND_NOTE_ON  = 4'h9;

	typedef enum logic [0:0] {
		REG_OUT_CHANNEL = 1'b0,
		REG_BYPASS      = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]        status_byte;
		logic [NOTE_W-1:0] data_one;
		logic [NOTE_W-1:0] data_two;
	} cmd_t;

	typedef struct packed {
		logic [7:0]        out_status_byte;
		logic [NOTE_W-1:0] out_data_one;
		logic [NOTE_W-1:0] out_data_two;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [CH_W-1:0]   data;
	} route_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mncr_route_mem.sv
`default_nettype none

module mncr_route_mem (
	input  wire logic                         clk,
	input  wire mncr_pkg::route_wr_t          wr,
	input  wire logic [mncr_pkg::SLOT_W-1:0]  rd_addr,
	output logic [mncr_pkg::CH_W-1:0]         rd_data
);
	import mncr_pkg::*;

	logic [CH_W-1:0] mem [TABLE_DEPTH];

	// Synchronous write, registered read; a read of the entry being written returns old data.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mncr_msg_logic.sv
`default_nettype none

module mncr_msg_logic (
	input  wire mncr_pkg::cmd_t               item,
	input  wire logic [mncr_pkg::CH_W-1:0]    route_ch,
	input  wire logic [mncr_pkg::CH_W-1:0]    out_channel,
	input  wire logic                         bypass,
	output mncr_pkg::result_t                 res,
	output mncr_pkg::route_wr_t               upd
);
	import mncr_pkg::*;

	logic [CH_W-1:0] kind;
	logic [CH_W-1:0] in_ch;
	logic [CH_W-1:0] target;
	logic            vel_zero;
	logic            is_off;
	logic            is_on;

	always_comb begin
		kind     = item.status_byte[7:4];
		in_ch    = item.status_byte[3:0];
		target   = bypass ? in_ch : out_channel;
		vel_zero = (item.data_two == '0);
		is_off   = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && vel_zero);
		is_on    = (kind == KIND_NOTE_ON) && !vel_zero;

		res.out_data_one = item.data_one;
		res.out_data_two = item.data_two;
		if (item.status_byte >= SYSTEM_STATUS) begin
			res.out_status_byte = item.status_byte;
		end else if (is_off) begin
			res.out_status_byte = {kind, route_ch};
		end else begin
			res.out_status_byte = {kind, target};
		end

		upd.we   = is_on;
		upd.addr = {in_ch, item.data_one};
		upd.data = target;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/midi_note_channel_remapper_core.sv
`default_nettype none
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  command   start, busy            cmd    (status_byte, data_one, data_two)
//  result    done (one-cycle pulse) result (out_status_byte, out_data_one,
//                                           out_data_two)
//  config    cfg_we                 cfg_index, cfg_data
//
//  A command transaction is taken at an edge where start is high and busy is low.
//  Its result pulses done from a register after stage 1. While busy is low, one
//  command can be taken every cycle. The rate is set by the route memory: one
//  read and one write port, with the write of a note-on forwarded to the command
//  that follows it directly. After reset, busy stays high while a clearing pass
//  loads each of the 2048 route entries with its own input channel, one entry per
//  cycle. The receiver cannot stall results; done lasts exactly one cycle.

module midi_note_channel_remapper_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire mncr_pkg::cmd_t                       cmd,
	output logic                                      done,
	output mncr_pkg::result_t                         result,
	input  wire logic                                 cfg_we,
	input  wire logic                                 cfg_index,
	input  wire logic [mncr_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mncr_pkg::*;

	// Clearing pass counter; its top bit marks the end of the pass.
	logic [SLOT_W:0]   clr_cnt_q;

	logic [CH_W-1:0]   out_channel_q;
	logic              bypass_q;

	// Stage 1 holds the accepted command while its route entry is read.
	logic              valid_s1;
	cmd_t              item_s1;

	// Last route write, registered so that the command directly after it can see it.
	logic              fwd_valid_q;
	logic [SLOT_W-1:0] fwd_addr_q;
	logic [CH_W-1:0]   fwd_data_q;

	logic              accept;
	logic [CH_W-1:0]   rd_data;
	logic [CH_W-1:0]   route_ch;
	route_wr_t         upd;
	route_wr_t         mem_wr;
	result_t           res;

	assign busy   = !clr_cnt_q[SLOT_W];
	assign accept = start && !busy;

	// The memory write port serves the clearing pass first, then note-on updates.
	always_comb begin
		if (busy) begin
			mem_wr.we   = 1'b1;
			mem_wr.addr = clr_cnt_q[SLOT_W-1:0];
			mem_wr.data = clr_cnt_q[SLOT_W-1:NOTE_W];
		end else begin
			mem_wr.we   = valid_s1 && upd.we;
			mem_wr.addr = upd.addr;
			mem_wr.data = upd.data;
		end
	end

	mncr_route_mem u_route_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_addr ({cmd.status_byte[3:0], cmd.data_one}),
		.rd_data (rd_data)
	);

	// The memory returns old data when the previous command wrote the same entry.
	assign route_ch = (fwd_valid_q && (fwd_addr_q == {item_s1.status_byte[3:0], item_s1.data_one}))
		? fwd_data_q : rd_data;

	mncr_msg_logic u_msg_logic (
		.item        (item_s1),
		.route_ch    (route_ch),
		.out_channel (out_channel_q),
		.bypass      (bypass_q),
		.res         (res),
		.upd         (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q     <= '0;
			out_channel_q <= '0;
			bypass_q      <= 1'b0;
			valid_s1      <= 1'b0;
			fwd_valid_q   <= 1'b0;
			done          <= 1'b0;
		end else begin
			if (busy) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					REG_OUT_CHANNEL: out_channel_q <= cfg_data[CH_W-1:0];
					REG_BYPASS:      bypass_q      <= cfg_data[0];
					default:         ;
				endcase
			end
			valid_s1    <= accept;
			fwd_valid_q <= valid_s1 && upd.we;
			done        <= valid_s1;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
		fwd_addr_q <= upd.addr;
		fwd_data_q <= upd.data;
		if (valid_s1) begin
			result <= res;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mncr_checker.sv
`default_nettype none

module mncr_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire mncr_pkg::cmd_t    cmd,
	input  wire logic              done,
	input  wire mncr_pkg::result_t result
);
	import mncr_pkg::*;

	// Every accepted command produces a result pulse.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result missing for accepted command");

	// No result appears without an earlier accepted command.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a command");

	// Once the clearing pass is over, busy never returns.
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(busy))
		else $error("busy rose after reset");

	// System messages and data bytes pass through untouched.
	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.status_byte >= SYSTEM_STATUS)) |=> ##1
		(result.out_status_byte == $past(cmd.status_byte, 2)) &&
		(result.out_data_one == $past(cmd.data_one, 2)) &&
		(result.out_data_two == $past(cmd.data_two, 2)))
		else $error("system message altered");

endmodule

bind midi_note_channel_remapper_core mncr_checker u_mncr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	import mncr_pkg::*;

	// Message kinds and system status bytes used by the stimulus, beyond the two
	// note kinds that the package already names.
	localparam logic [3:0] KIND_POLY_PRESSURE = 4'hA;
	localparam logic [3:0] KIND_CONTROL       = 4'hB;
	localparam logic [3:0] KIND_PROGRAM       = 4'hC;
	localparam logic [3:0] KIND_CHAN_PRESSURE = 4'hD;
	localparam logic [3:0] KIND_PITCH_BEND    = 4'hE;
	localparam logic [7:0] SYS_TIMING_CLOCK   = 8'hF8;
	localparam logic [7:0] SYS_RESET          = 8'hFF;

	localparam int HELD_LIMIT = 96;
	localparam int PHASE_ITEMS = 280;

	// Tracks the remapper's route table and registers, and holds the remapped
	// messages that are still due from the block, oldest first.
	class remap_tracker;
		logic [CH_W-1:0] route [TABLE_DEPTH];
		logic [CH_W-1:0] out_channel;
		logic            bypass;
		result_t         remapped_msgs [$];
		int              mismatch_count;
		int              note_on_count;
		int              note_off_count;
		int              system_count;
		int              other_count;

		function new();
			for (int i = 0; i < TABLE_DEPTH; i++)
				route[i] = CH_W'(i / (1 << NOTE_W));
			out_channel = '0;
			bypass = 1'b0;
			mismatch_count = 0;
			note_on_count = 0;
			note_off_count = 0;
			system_count = 0;
			other_count = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_OUT_CHANNEL)
				out_channel = value[CH_W-1:0];
			else
				bypass = value[0];
		endfunction

		function int pending();
			return remapped_msgs.size();
		endfunction

		// Works out the outgoing message for one command and applies its side
		// effect on the route table.
		function result_t remap_message(cmd_t c);
			result_t         r;
			logic [3:0]      kind;
			logic [CH_W-1:0] in_ch;
			logic [CH_W-1:0] target;
			logic [SLOT_W-1:0] slot;
			bit              is_off;
			bit              is_on;
			r.out_status_byte = c.status_byte;
			r.out_data_one = c.data_one;
			r.out_data_two = c.data_two;
			if (c.status_byte < SYSTEM_STATUS) begin
				kind = c.status_byte[7:4];
				in_ch = c.status_byte[3:0];
				target = bypass ? in_ch : out_channel;
				slot = {in_ch, c.data_one};
				is_off = (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON && c.data_two == 0);
				is_on = (kind == KIND_NOTE_ON) && (c.data_two != 0);
				r.out_status_byte = {kind, is_off ? route[slot] : target};
				if (is_on)
					route[slot] = target;
				if (is_on)
					note_on_count++;
				else if (is_off)
					note_off_count++;
				else
					other_count++;
			end else begin
				system_count++;
			end
			return r;
		endfunction

		function void note_command(cmd_t c);
			remapped_msgs.push_back(remap_message(c));
		endfunction

		function void check_result(result_t r);
			result_t want;
			if (remapped_msgs.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, r);
				mismatch_count++;
				return;
			end
			want = remapped_msgs.pop_front();
			if (r.out_status_byte !== want.out_status_byte) begin
				$display("%0t: out_status_byte expected %h actual %h",
					$time, want.out_status_byte, r.out_status_byte);
				mismatch_count++;
			end
			if (r.out_data_one !== want.out_data_one) begin
				$display("%0t: out_data_one expected %h actual %h",
					$time, want.out_data_one, r.out_data_one);
				mismatch_count++;
			end
			if (r.out_data_two !== want.out_data_two) begin
				$display("%0t: out_data_two expected %h actual %h",
					$time, want.out_data_two, r.out_data_two);
				mismatch_count++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	cmd_t                  cmd = '0;
	logic                  done;
	result_t               result;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = REG_OUT_CHANNEL;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	remap_tracker tracker = new();

	// Slots (input channel and note) of notes that were switched on and not yet
	// switched off; note-offs are mostly drawn from here so that they hit routes
	// that a note-on wrote, often under a register setting of an earlier phase.
	logic [SLOT_W-1:0] held_notes [$];
	int settings_used = 0;

	midi_note_channel_remapper_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Both handshakes are sampled at the rising edge, before any of the values
	// driven at that edge take effect. Results are checked before the command of
	// the same edge is noted; as done is registered after stage 1, they never belong to it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(result);
			if (start && !busy)
				tracker.note_command(cmd);
		end
	end

	// Presents one command and holds it until the block takes the transaction.
	// Returns right after the accepting edge.
	task automatic drive_command(input cmd_t c);
		cmd <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Idles the sender for a random number of cycles, then sends one command.
	task automatic send_msg(input logic [7:0] status, input logic [6:0] d1,
		input logic [6:0] d2, input int idle_pct);
		cmd_t c;
		c.status_byte = status;
		c.data_one = d1;
		c.data_two = d2;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		drive_command(c);
	endtask

	// A register write lowers the write enable again before it returns, so that the enable
	// is never lowered and raised within one time step when writes follow each other.
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every result that is due has come, then idles further so
	// the pipeline is empty before the registers change.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [CH_W-1:0] chan, input logic byp);
		write_reg(REG_OUT_CHANNEL, chan);
		// The upper data bits are don't-care for the one-bit register.
		write_reg(REG_BYPASS, {3'($urandom_range(7)), byp});
		settings_used++;
	endtask

	// Draws one random message. Most traffic is note-on and note-off pairs with
	// random content; the rest is other channel messages, system messages,
	// status bytes below the valid range and note-offs for notes never held.
	function automatic cmd_t pick_message();
		cmd_t c;
		int   roll;
		int   idx;
		logic [SLOT_W-1:0] slot;
		c.data_one = 7'($urandom_range(127));
		c.data_two = 7'($urandom_range(127));
		roll = $urandom_range(99);
		if (held_notes.size() >= HELD_LIMIT && roll < 35)
			roll = 35;
		if (held_notes.size() == 0 && roll >= 35 && roll < 65)
			roll = 0;
		if (roll < 35) begin
			c.status_byte = {KIND_NOTE_ON, 4'($urandom_range(15))};
			c.data_two = 7'($urandom_range(127, 1));
			held_notes.push_back({c.status_byte[3:0], c.data_one});
		end else if (roll < 65) begin
			// Favor the latest note so that an off often directly follows its on.
			if ($urandom_range(99) < 30)
				idx = held_notes.size() - 1;
			else
				idx = $urandom_range(held_notes.size() - 1);
			slot = held_notes[idx];
			held_notes.delete(idx);
			c.data_one = slot[NOTE_W-1:0];
			if ($urandom_range(1) == 0) begin
				c.status_byte = {KIND_NOTE_OFF, slot[SLOT_W-1:NOTE_W]};
			end else begin
				c.status_byte = {KIND_NOTE_ON, slot[SLOT_W-1:NOTE_W]};
				c.data_two = '0;
			end
		end else if (roll < 72) begin
			c.status_byte = {KIND_NOTE_OFF, 4'($urandom_range(15))};
		end else if (roll < 86) begin
			c.status_byte = {4'($urandom_range(KIND_PITCH_BEND, KIND_POLY_PRESSURE)),
				4'($urandom_range(15))};
		end else if (roll < 94) begin
			c.status_byte = 8'($urandom_range(255, SYSTEM_STATUS));
		end else begin
			c.status_byte = 8'($urandom_range(127));
		end
		return c;
	endfunction

	initial begin
		int idle_pct;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The clearing pass after reset keeps busy high for the whole table.
		while (busy)
			@(posedge clk);
		configure(4'd5, 1'b0);

		// Directed part, back to back. A note-on directly followed by its
		// note-off exercises the forwarding path of the route memory.
		send_msg({KIND_NOTE_ON, 4'd3}, 7'd0, 7'd127, 0);
		send_msg({KIND_NOTE_OFF, 4'd3}, 7'd0, 7'd0, 0);
		send_msg({KIND_NOTE_ON, 4'd3}, 7'd127, 7'd1, 0);
		send_msg({KIND_NOTE_ON, 4'd3}, 7'd127, 7'd0, 0);
		send_msg({KIND_NOTE_OFF, 4'd10}, 7'd64, 7'd64, 0);
		send_msg({KIND_NOTE_ON, 4'd15}, 7'd60, 7'd0, 0);
		send_msg({KIND_NOTE_OFF, 4'd0}, 7'd127, 7'd127, 0);
		send_msg({KIND_NOTE_ON, 4'd0}, 7'd42, 7'd100, 0);
		send_msg({KIND_POLY_PRESSURE, 4'd7}, 7'd0, 7'd127, 0);
		send_msg({KIND_CONTROL, 4'd0}, 7'd127, 7'd0, 0);
		send_msg({KIND_PROGRAM, 4'd15}, 7'd85, 7'd42, 0);
		send_msg({KIND_CHAN_PRESSURE, 4'd1}, 7'd127, 7'd127, 0);
		send_msg({KIND_PITCH_BEND, 4'd8}, 7'd0, 7'd0, 0);
		send_msg(SYSTEM_STATUS, 7'd127, 7'd127, 0);
		send_msg(SYS_TIMING_CLOCK, 7'd0, 7'd0, 0);
		send_msg(SYS_RESET, 7'd85, 7'd42, 0);
		send_msg(8'h00, 7'd0, 7'd127, 0);
		send_msg(8'h7F, 7'd127, 7'd0, 0);
		send_msg(8'h45, 7'd42, 7'd85, 0);
		settle();

		// Bypass: a note-on stores its own channel, and a note-off that follows
		// later under a new target must still go back there.
		configure(4'd0, 1'b1);
		send_msg({KIND_NOTE_ON, 4'd12}, 7'd42, 7'd90, 0);
		send_msg({KIND_NOTE_OFF, 4'd0}, 7'd42, 7'd10, 0);
		settle();
		configure(4'd15, 1'b0);
		send_msg({KIND_NOTE_OFF, 4'd12}, 7'd42, 7'd0, 0);
		send_msg({KIND_NOTE_ON, 4'd0}, 7'd42, 7'd0, 0);

		// Random part: six register settings, two per idling regime. Notes held
		// over a phase boundary are released under a different setting.
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0: configure(4'd15, 1'b0);
				1: configure(4'd0, 1'b1);
				2: configure(4'($urandom_range(15)), 1'b0);
				3: configure(4'($urandom_range(15)), 1'b1);
				4: configure(4'd0, 1'b0);
				default: configure(4'($urandom_range(15)), 1'b0);
			endcase
			idle_pct = (phase < 2) ? 28 : (phase < 4) ? 73 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				cmd_t c;
				c = pick_message();
				send_msg(c.status_byte, c.data_one, c.data_two, idle_pct);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Run covered %0d note-on, %0d note-off, %0d system and %0d other messages",
			tracker.note_on_count, tracker.note_off_count, tracker.system_count,
			tracker.other_count);
		$display("under %0d register settings, with bypass on and off.", settings_used);
		if (tracker.mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout: results still due %0d", tracker.pending());
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/mncr_pkg.sv
hw/rtl/mncr_route_mem.sv
hw/rtl/mncr_msg_logic.sv
hw/rtl/midi_note_channel_remapper_core.sv
hw/rtl/mncr_checker.sv
verif/testbench.sv
